/* rtl/core/indexed_min_heap_decrement_unit_macros.svh */
// Assertion macros for the indexed min-heap unit
`ifndef INDEXED_MIN_HEAP_DECREMENT_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_DECREMENT_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define IHD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap unit check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define IHD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap unit check failed");

`endif

/* rtl/core/ihd_pkg.sv */
// Shared constants, types and helpers for the indexed min-heap unit
`default_nettype none

package ihd_pkg;

  localparam int HEAP_SIZE  = 1024;
  localparam int VALUE_BITS = 16;

  localparam int KEY_W      = 10;
  localparam int KEY_SPACE  = 1 << KEY_W;
  localparam int IN_VALUE_W = 16;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int HELD_W     = 11;

  localparam int SLOT_W = $clog2(HEAP_SIZE);
  localparam int CNT_W  = $clog2(HEAP_SIZE + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DEC    = 2'd1,
    CMD_POP    = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_POP_EMPTY = 3'd1,
    ST_FULL      = 3'd2,
    ST_PRESENT   = 3'd3,
    ST_ABSENT    = 3'd4
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
  } slot_t;

  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } pos_t;

  function automatic logic [VALUE_BITS-1:0] value_from_port(input logic [IN_VALUE_W-1:0] x);
    logic [VALUE_BITS+IN_VALUE_W-1:0] t;
    t = {{VALUE_BITS{1'b0}}, x};
    return t[VALUE_BITS-1:0];
  endfunction

  function automatic logic [IN_VALUE_W-1:0] value_to_port(input logic [VALUE_BITS-1:0] x);
    logic [VALUE_BITS+IN_VALUE_W-1:0] t;
    t = {{IN_VALUE_W{1'b0}}, x};
    return t[IN_VALUE_W-1:0];
  endfunction

  function automatic logic [HELD_W-1:0] count_to_port(input logic [CNT_W-1:0] x);
    logic [CNT_W+HELD_W-1:0] t;
    t = {{HELD_W{1'b0}}, x};
    return t[HELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ihd_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module ihd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/indexed_min_heap_decrement_unit.sv */
// Indexed binary min-heap with insert, decrement-by-one and pop-minimum
//
//  channel | ports                                       | handshake
//  --------+---------------------------------------------+-------------------------
//  request | in_command, in_item_key, in_item_value      | start && !busy
//  result  | out_key, out_value, out_status,             | out_valid, one cycle,
//          | out_entries_held                            | no back-pressure
//
// Errors and a pop of the sole entry end in S_POS; insert sifts up through S_UP_ISSUE
// and S_UP_CMP, and decrement first reads the slot in S_DEC_RD; pop reads the last entry
// in S_POP_LAST and sifts it down, with up to two child reads per level on the one slot
// RAM read port. The result strobe comes with busy low; the next request can be taken then.
// Slot RAM (key, value) and key position RAM each do one read, one write a cycle.
// After reset a clearing pass marks all 1024 keys absent; busy is high.
// Requests are taken only while busy is low; results cannot be stalled.
`default_nettype none

module indexed_min_heap_decrement_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output      logic                           busy,
  input  wire logic [ihd_pkg::CMD_W-1:0]      in_command,
  input  wire logic [ihd_pkg::KEY_W-1:0]      in_item_key,
  input  wire logic [ihd_pkg::IN_VALUE_W-1:0] in_item_value,
  output      logic                           out_valid,
  output      logic [ihd_pkg::KEY_W-1:0]      out_key,
  output      logic [ihd_pkg::IN_VALUE_W-1:0] out_value,
  output      logic [ihd_pkg::STATUS_W-1:0]   out_status,
  output      logic [ihd_pkg::HELD_W-1:0]     out_entries_held
);

  import ihd_pkg::*;

  `include "indexed_min_heap_decrement_unit_macros.svh"

  localparam int W2 = SLOT_W + 2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_POS, S_DEC_RD, S_UP_ISSUE, S_UP_CMP,
    S_POP_LAST, S_DN_ISSUE, S_DN_L, S_DN_R
  } state_t;

  state_t                state_r, state_nxt;
  logic [KEY_W-1:0]      clr_r, clr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  slot_t                 mov_r, mov_nxt;
  slot_t                 left_r, left_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]      out_key_r, out_key_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [CNT_W-1:0]      out_held_r, out_held_nxt;

  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr, slot_raddr;
  slot_t             slot_wdata, slot_rdata;
  logic              pos_we;
  logic [KEY_W-1:0]  pos_waddr, pos_raddr;
  pos_t              pos_wdata, pos_rdata;

  logic [W2-1:0]     left_w, right_w, cnt_w, pos_w;
  logic [SLOT_W-1:0] parent_idx;
  slot_t             child;
  logic [SLOT_W-1:0] child_idx;

  ihd_ram #(.WIDTH($bits(slot_t)), .DEPTH(HEAP_SIZE)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  ihd_ram #(.WIDTH($bits(pos_t)), .DEPTH(KEY_SPACE)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  assign left_w     = {1'b0, idx_r, 1'b1};
  assign right_w    = left_w + W2'(1);
  assign cnt_w      = {{(W2-CNT_W){1'b0}}, count_r};
  assign pos_w      = {2'b00, pos_rdata.slot};
  assign parent_idx = SLOT_W'((idx_r - SLOT_W'(1)) >> 1);

  // in S_DN_R the right child wins only when strictly smaller
  always_comb begin
    child     = left_r;
    child_idx = left_w[SLOT_W-1:0];
    if (state_r == S_DN_L) begin
      child = slot_rdata;
    end else if (slot_rdata.value < left_r.value) begin
      child     = slot_rdata;
      child_idx = right_w[SLOT_W-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    count_nxt      = count_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    mov_nxt        = mov_r;
    left_nxt       = left_r;
    out_valid_nxt  = 1'b0;
    out_key_nxt    = out_key_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_held_nxt   = out_held_r;

    slot_we    = 1'b0;
    slot_waddr = idx_r;
    slot_wdata = mov_r;
    slot_raddr = '0;
    pos_we     = 1'b0;
    pos_waddr  = mov_r.key;
    pos_wdata  = '{present: 1'b1, slot: idx_r};
    pos_raddr  = in_item_key;

    unique case (state_r)
      S_CLEAR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_r;
        pos_wdata = '{present: 1'b0, slot: '0};
        clr_nxt   = clr_r + KEY_W'(1);
        if (clr_r == KEY_W'(KEY_SPACE - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // position of the key and slot 0 are both read here
        if (start) begin
          cmd_nxt   = cmd_t'(in_command);
          key_nxt   = in_item_key;
          val_nxt   = value_from_port(in_item_value);
          state_nxt = S_POS;
        end
      end

      S_POS: begin
        out_key_nxt   = '0;
        out_value_nxt = '0;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (pos_rdata.present) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_PRESENT;
              state_nxt      = S_IDLE;
            end else if (count_r == CNT_W'(HEAP_SIZE)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_FULL;
              state_nxt      = S_IDLE;
            end else begin
              mov_nxt   = '{key: key_r, value: val_r};
              idx_nxt   = count_r[SLOT_W-1:0];
              count_nxt = count_r + CNT_W'(1);
              state_nxt = S_UP_ISSUE;
            end
          end
          CMD_DEC: begin
            if (!pos_rdata.present) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_ABSENT;
              state_nxt      = S_IDLE;
            end else if (pos_w >= cnt_w) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              state_nxt      = S_IDLE;
            end else begin
              idx_nxt    = pos_rdata.slot;
              slot_raddr = pos_rdata.slot;
              state_nxt  = S_DEC_RD;
            end
          end
          CMD_POP: begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_POP_EMPTY;
              state_nxt      = S_IDLE;
            end else begin
              out_key_nxt    = slot_rdata.key;
              out_value_nxt  = slot_rdata.value;
              out_status_nxt = ST_OK;
              pos_we         = 1'b1;
              pos_waddr      = slot_rdata.key;
              pos_wdata      = '{present: 1'b0, slot: '0};
              count_nxt      = count_r - CNT_W'(1);
              idx_nxt        = '0;
              if (count_r == CNT_W'(1)) begin
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end else begin
                slot_raddr = SLOT_W'(count_r - CNT_W'(1));
                state_nxt  = S_POP_LAST;
              end
            end
          end
          default: begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            state_nxt      = S_IDLE;
          end
        endcase
      end

      S_DEC_RD: begin
        mov_nxt.key   = key_r;
        mov_nxt.value = (slot_rdata.value == '0) ? '0 : slot_rdata.value - VALUE_BITS'(1);
        state_nxt     = S_UP_ISSUE;
      end

      S_UP_ISSUE: begin
        if (idx_r == '0) begin
          slot_we        = 1'b1;
          pos_we         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_key_nxt    = '0;
          out_value_nxt  = '0;
          state_nxt      = S_IDLE;
        end else begin
          slot_raddr = parent_idx;
          state_nxt  = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
        if (slot_rdata.value > mov_r.value) begin
          // parent moves down into the hole; the moving entry stays in registers
          slot_wdata = slot_rdata;
          pos_waddr  = slot_rdata.key;
          idx_nxt    = parent_idx;
          state_nxt  = S_UP_ISSUE;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_key_nxt    = '0;
          out_value_nxt  = '0;
          state_nxt      = S_IDLE;
        end
      end

      S_POP_LAST: begin
        mov_nxt   = slot_rdata;
        state_nxt = S_DN_ISSUE;
      end

      S_DN_ISSUE: begin
        if (left_w >= cnt_w) begin
          slot_we       = 1'b1;
          pos_we        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          slot_raddr = left_w[SLOT_W-1:0];
          state_nxt  = S_DN_L;
        end
      end

      S_DN_L, S_DN_R: begin
        if (state_r == S_DN_L && right_w < cnt_w) begin
          left_nxt   = slot_rdata;
          slot_raddr = right_w[SLOT_W-1:0];
          state_nxt  = S_DN_R;
        end else begin
          slot_we = 1'b1;
          pos_we  = 1'b1;
          if (child.value < mov_r.value) begin
            slot_wdata = child;
            pos_waddr  = child.key;
            idx_nxt    = child_idx;
            state_nxt  = S_DN_ISSUE;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_valid_nxt) begin
      out_held_nxt = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      cmd_r        <= cmd_nxt;
      key_r        <= key_nxt;
      val_r        <= val_nxt;
      idx_r        <= idx_nxt;
      mov_r        <= mov_nxt;
      left_r       <= left_nxt;
      out_key_r    <= out_key_nxt;
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
      out_held_r   <= out_held_nxt;
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_key          = out_key_r;
  assign out_value        = value_to_port(out_value_r);
  assign out_status       = out_status_r;
  assign out_entries_held = count_to_port(out_held_r);

  `IHD_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  `IHD_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `IHD_ASSERT_NOW(a_idle_on_result, out_valid, !busy)
  `IHD_ASSERT_NOW(a_error_zero_payload, out_valid && (out_status != ST_OK), (out_key == '0) && (out_value == '0))
  `IHD_ASSERT_NOW(a_up_not_root, state_r == S_UP_CMP, idx_r != '0)

endmodule

`default_nettype wire
